[rtl/core/mpss_pkg.sv]
// shared types and codes of the mesh path slot scheduler
`default_nettype none

package mpss_pkg;

    // bitmap length in ticks and slots of the ack wheel
    localparam int TICKS      = 64;
    localparam int LINK_KINDS = 5;

    // input item kinds, carried on tuser
    localparam logic CMD_REQ  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // result kinds, carried on tuser
    localparam logic RK_ACK    = 1'b0;
    localparam logic RK_REJECT = 1'b1;

    // configuration register indexes
    localparam logic [2:0] CFG_ROWS   = 3'd0;
    localparam logic [2:0] CFG_COLS   = 3'd1;
    localparam logic [2:0] CFG_ACKALL = 3'd2;
    localparam logic [2:0] CFG_RESV   = 3'd3;
    localparam logic [2:0] CFG_MAXPAR = 3'd4;

    // link kinds along an xy path
    typedef enum logic [2:0] {
        LK_WEST  = 3'd0,
        LK_EAST  = 3'd1,
        LK_NORTH = 3'd2,
        LK_SOUTH = 3'd3,
        LK_CORE  = 3'd4
    } t_link;

    // one flow, packed as on tdata
    typedef struct packed {
        logic [5:0]  port;
        logic [15:0] tag;
        logic [5:0]  flits;
        logic [5:0]  dst;
        logic [5:0]  src;
    } t_flow;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SWEEP_RD,
        ST_SWEEP_WR,
        ST_SEL,
        ST_DIV,
        ST_GATH_RD,
        ST_GATH_WT,
        ST_SEARCH,
        ST_FILL_RD,
        ST_FILL_CHK,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_RES_RD,
        ST_RES_WR,
        ST_NEXT,
        ST_EMIT_RD,
        ST_EMIT_N,
        ST_EMIT_WRD,
        ST_EMIT_OUT,
        ST_EMIT_END
    } t_state;

endpackage

`default_nettype wire

[rtl/core/mesh_path_slot_scheduler.sv]
// top level of the mesh path slot scheduler
`default_nettype none

// Central xy-routing link scheduler. A request item is acked at once when ack-all is
// set, else rejected when the queue is full, or queued. A tick item first ages every
// link bitmap in a read/write sweep of the link memory, then walks the queue; each
// examined request passes through selection, node-id division, a gather of the path
// bitmaps link by link, a window search (one offset per cycle), a slot-fill lookup,
// marking or reserving of the path link by link and an update of the queue. The walk
// ends when the queue runs out or when a nonzero MAXPAR count of requests is examined.
// Acks of the current wheel slot then leave one at a time, each waiting until the one
// before it is taken, and the slot bookkeeping follows. After reset a clearing pass
// zeroes the link and slot fill memories; no item is taken until it ends.
module mesh_path_slot_scheduler
    import mpss_pkg::*;
#(
    parameter int MAX_ROWS    = 8,
    parameter int MAX_COLUMNS = 8,
    parameter int QUEUE_DEPTH = 16,
    parameter int SLOT_DEPTH  = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_addr,
    input  wire  [4:0]  i_cfg_wdata,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    // src_node, dst_node, flit_count, request_tag, return_port
    input  wire  [39:0] i_s_tdata,
    // cmd
    input  wire         i_s_tuser,
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    // ack_src, ack_dst, ack_flits, ack_tag, ack_port
    output logic [39:0] o_m_tdata,
    // kind
    output logic        o_m_tuser,
    output logic        o_m_tlast
);

    localparam int NODES = MAX_ROWS * MAX_COLUMNS;
    localparam int LINKS = LINK_KINDS * NODES;
    localparam int AW    = (LINKS > 1) ? $clog2(LINKS) : 1;
    localparam int CLR_N = (LINKS > TICKS) ? LINKS : TICKS;
    localparam int CW    = $clog2(CLR_N + 1);
    localparam int QCW   = $clog2(QUEUE_DEPTH + 1);
    localparam int QIW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int EXW   = (QCW > 5) ? QCW : 5;
    localparam int FW    = $clog2(SLOT_DEPTH + 1);
    localparam int WAW   = $clog2(TICKS * SLOT_DEPTH);

    // configuration registers
    logic [3:0] r_rows, r_cols;
    logic       r_ackall, r_resv;
    logic [4:0] r_maxpar;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows   <= 4'd4;
            r_cols   <= 4'd4;
            r_ackall <= 1'b0;
            r_resv   <= 1'b0;
            r_maxpar <= 5'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_ROWS:   r_rows   <= i_cfg_wdata[3:0];
                CFG_COLS:   r_cols   <= i_cfg_wdata[3:0];
                CFG_ACKALL: r_ackall <= i_cfg_wdata[0];
                CFG_RESV:   r_resv   <= i_cfg_wdata[0];
                CFG_MAXPAR: r_maxpar <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // effective mesh size
    logic [3:0] rows_eff, cols_eff;
    always_comb begin
        if (r_rows == 4'd0) rows_eff = 4'd1;
        else if (int'(r_rows) > MAX_ROWS) rows_eff = 4'(MAX_ROWS);
        else rows_eff = r_rows;
        if (r_cols == 4'd0) cols_eff = 4'd1;
        else if (int'(r_cols) > MAX_COLUMNS) cols_eff = 4'(MAX_COLUMNS);
        else cols_eff = r_cols;
    end

    // memories: link bitmaps {reserve, usage}, ack wheel, slot fill counts
    logic [127:0]   m_link [LINKS];
    t_flow          m_wheel [TICKS * SLOT_DEPTH];
    logic [FW-1:0]  m_fill [TICKS];

    logic           lre, lwe;
    logic [AW-1:0]  lra, lwa;
    logic [127:0]   lwd, r_lrd;
    logic           wre, wwe;
    logic [WAW-1:0] wra, wwa;
    t_flow          wwd, r_wrd;
    logic           fre, fwe;
    logic [5:0]     fra, fwa;
    logic [FW-1:0]  fwd, r_frd;

    always_ff @(posedge i_clk) begin
        if (lwe) m_link[lwa] <= lwd;
        if (lre) r_lrd <= m_link[lra];
        if (wwe) m_wheel[wwa] <= wwd;
        if (wre) r_wrd <= m_wheel[wra];
        if (fwe) m_fill[fwa] <= fwd;
        if (fre) r_frd <= m_fill[fra];
    end

    // control and payload registers
    t_state         r_state, n_state;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic [QCW-1:0] r_qcount, n_qcount, r_i, n_i;
    logic [EXW-1:0] r_ex, n_ex;
    logic [5:0]     r_base, n_base;
    logic           r_ov, n_ov;

    t_flow          r_q [QUEUE_DEPTH];
    t_flow          n_q [QUEUE_DEPTH];
    t_flow          r_cur, n_cur;
    logic [5:0]     r_sr, n_sr, r_sq, n_sq, r_dm, n_dm, r_dq, n_dq;
    logic [3:0]     r_pr, n_pr, r_pc, n_pc, r_dr, n_dr, r_dc, n_dc;
    logic [3:0]     r_r, n_r, r_c, n_c;
    logic [4:0]     r_hop, n_hop;
    logic [63:0]    r_acc, n_acc, r_mask, n_mask;
    logic [6:0]     r_t, n_t;
    logic [5:0]     r_slot, n_slot;
    logic           r_done, n_done;
    logic [FW-1:0]  r_n, n_n, r_k, n_k;
    t_flow          r_od, n_od;
    logic           r_ok, n_ok, r_ol, n_ol;

    // one xy step from the current walk position
    logic          p_at;
    t_link         p_kind;
    logic [3:0]    p_nr, p_nc;
    logic [AW-1:0] p_addr;
    always_comb begin
        p_at = (r_r == r_dr) && (r_c == r_dc);
        p_nr = r_r;
        p_nc = r_c;
        if (p_at) begin
            p_kind = LK_CORE;
        end else if (r_c < r_dc) begin
            p_kind = LK_WEST;
            p_nc   = r_c + 4'd1;
        end else if (r_c > r_dc) begin
            p_kind = LK_EAST;
            p_nc   = r_c - 4'd1;
        end else if (r_r < r_dr) begin
            p_kind = LK_NORTH;
            p_nr   = r_r + 4'd1;
        end else begin
            p_kind = LK_SOUTH;
            p_nr   = r_r - 4'd1;
        end
        p_addr = AW'(int'(p_kind) * NODES + int'(r_r) * MAX_COLUMNS + int'(r_c));
    end

    t_flow      in_flow;
    logic       in_acc, win_free;
    logic [5:0] slot_t;
    int         limit;
    assign in_flow  = t_flow'(i_s_tdata);
    assign in_acc   = i_s_tvalid && o_s_tready;
    assign win_free = (r_acc & r_mask) == 64'd0;
    assign slot_t   = r_base + r_t[5:0];
    assign limit    = TICKS - int'(r_cur.flits) - int'(r_hop);

    // next state and memory controls
    always_comb begin
        n_state = r_state;  n_cnt = r_cnt;  n_qcount = r_qcount;  n_i = r_i;
        n_ex = r_ex;  n_base = r_base;  n_q = r_q;  n_cur = r_cur;
        n_sr = r_sr;  n_sq = r_sq;  n_dm = r_dm;  n_dq = r_dq;
        n_pr = r_pr;  n_pc = r_pc;  n_dr = r_dr;  n_dc = r_dc;  n_r = r_r;  n_c = r_c;
        n_hop = r_hop;  n_acc = r_acc;  n_mask = r_mask;  n_t = r_t;  n_slot = r_slot;
        n_done = r_done;  n_n = r_n;  n_k = r_k;
        n_od = r_od;  n_ok = r_ok;  n_ol = r_ol;
        n_ov = r_ov && !i_m_tready;
        lre = 1'b0;  lwe = 1'b0;  lra = p_addr;  lwa = p_addr;  lwd = r_lrd;
        wre = 1'b0;  wwe = 1'b0;  wra = '0;  wwa = '0;  wwd = r_cur;
        fre = 1'b0;  fwe = 1'b0;  fra = r_base;  fwa = r_base;  fwd = '0;
        o_s_tready = (r_state == ST_IDLE) && !r_ov;

        case (r_state)
            // zero link and fill memories after reset
            ST_CLEAR: begin
                if (int'(r_cnt) < LINKS) begin
                    lwe = 1'b1;
                    lwa = r_cnt[AW-1:0];
                    lwd = '0;
                end
                if (int'(r_cnt) < TICKS) begin
                    fwe = 1'b1;
                    fwa = r_cnt[5:0];
                end
                n_cnt = r_cnt + CW'(1);
                if (int'(r_cnt) == CLR_N - 1) n_state = ST_IDLE;
            end
            // take one item
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_s_tuser == CMD_TICK) begin
                        n_cnt   = '0;
                        n_state = ST_SWEEP_RD;
                    end else if (r_ackall) begin
                        n_ov = 1'b1;  n_od = in_flow;  n_ok = RK_ACK;  n_ol = 1'b1;
                    end else if (int'(r_qcount) >= QUEUE_DEPTH) begin
                        n_ov = 1'b1;  n_od = in_flow;  n_ok = RK_REJECT;  n_ol = 1'b1;
                    end else begin
                        n_q[r_qcount[QIW-1:0]] = in_flow;
                        n_qcount = r_qcount + QCW'(1);
                    end
                end
            end
            // age usage, drop reservations
            ST_SWEEP_RD: begin
                lre     = 1'b1;
                lra     = r_cnt[AW-1:0];
                n_state = ST_SWEEP_WR;
            end
            ST_SWEEP_WR: begin
                lwe   = 1'b1;
                lwa   = r_cnt[AW-1:0];
                lwd   = {64'd0, r_lrd[63:0] >> 1};
                n_cnt = r_cnt + CW'(1);
                if (int'(r_cnt) == LINKS - 1) begin
                    n_i     = '0;
                    n_ex    = '0;
                    n_state = ST_SEL;
                end else begin
                    n_state = ST_SWEEP_RD;
                end
            end
            // pick the next queued request
            ST_SEL: begin
                if (r_i < r_qcount) begin
                    n_cur   = r_q[r_i[QIW-1:0]];
                    n_sr    = n_cur.src;
                    n_dm    = n_cur.dst;
                    n_sq    = '0;
                    n_dq    = '0;
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_EMIT_RD;
                end
            end
            // node id to row and column by repeated subtraction
            ST_DIV: begin
                if (r_sr >= {2'b00, cols_eff}) begin
                    n_sr = r_sr - {2'b00, cols_eff};
                    n_sq = r_sq + 6'd1;
                end
                if (r_dm >= {2'b00, cols_eff}) begin
                    n_dm = r_dm - {2'b00, cols_eff};
                    n_dq = r_dq + 6'd1;
                end
                if (r_sr < {2'b00, cols_eff} && r_dm < {2'b00, cols_eff}) begin
                    n_pr = (r_sq >= {2'b00, rows_eff}) ? rows_eff - 4'd1 : r_sq[3:0];
                    n_pc = r_sr[3:0];
                    n_dr = (r_dq >= {2'b00, rows_eff}) ? rows_eff - 4'd1 : r_dq[3:0];
                    n_dc = r_dm[3:0];
                    n_r  = n_pr;
                    n_c  = n_pc;
                    n_acc = '0;
                    n_hop = '0;
                    n_state = ST_GATH_RD;
                end
            end
            // or the path bitmaps, each offset by its hop, reservations only when enabled
            ST_GATH_RD: begin
                lre     = 1'b1;
                n_state = ST_GATH_WT;
            end
            ST_GATH_WT: begin
                n_acc = r_acc | (r_lrd[63:0] >> r_hop)
                      | (r_resv ? (r_lrd[127:64] >> r_hop) : 64'd0);
                if (p_at) begin
                    n_t     = '0;
                    n_mask  = (64'd1 << r_cur.flits) - 64'd1;
                    n_state = ST_SEARCH;
                end else begin
                    n_hop   = r_hop + 5'd1;
                    n_r     = p_nr;
                    n_c     = p_nc;
                    n_state = ST_GATH_RD;
                end
            end
            // one window offset per cycle
            ST_SEARCH: begin
                if (int'(r_t) < limit) begin
                    if (win_free) begin
                        n_state = ST_FILL_RD;
                    end else begin
                        n_mask = r_mask << 1;
                        n_t    = r_t + 7'd1;
                    end
                end else if (r_resv && int'(r_t) < TICKS) begin
                    if (win_free) begin
                        n_r     = r_pr;
                        n_c     = r_pc;
                        n_state = ST_RES_RD;
                    end else begin
                        n_mask = r_mask << 1;
                        n_t    = r_t + 7'd1;
                    end
                end else begin
                    n_done  = 1'b0;
                    n_state = ST_NEXT;
                end
            end
            // check room in the target wheel slot
            ST_FILL_RD: begin
                fre     = 1'b1;
                fra     = slot_t;
                n_slot  = slot_t;
                n_state = ST_FILL_CHK;
            end
            ST_FILL_CHK: begin
                if (int'(r_frd) < SLOT_DEPTH) begin
                    wwe     = 1'b1;
                    wwa     = WAW'(int'(r_slot) * SLOT_DEPTH + int'(r_frd));
                    fwe     = 1'b1;
                    fwa     = r_slot;
                    fwd     = r_frd + FW'(1);
                    n_done  = 1'b1;
                    n_r     = r_pr;
                    n_c     = r_pc;
                    n_state = ST_MARK_RD;
                end else begin
                    n_done  = 1'b0;
                    n_state = ST_NEXT;
                end
            end
            // mark the window along the path
            ST_MARK_RD: begin
                lre     = 1'b1;
                n_state = ST_MARK_WR;
            end
            ST_MARK_WR: begin
                lwe    = 1'b1;
                lwd    = {r_lrd[127:64], r_lrd[63:0] | r_mask};
                n_mask = r_mask << 1;
                n_r    = p_nr;
                n_c    = p_nc;
                n_state = p_at ? ST_NEXT : ST_MARK_RD;
            end
            // reserve the path tail, core link overwritten
            ST_RES_RD: begin
                lre     = 1'b1;
                n_state = ST_RES_WR;
            end
            ST_RES_WR: begin
                lwe    = 1'b1;
                lwd    = {p_at ? r_mask : (r_lrd[127:64] | r_mask), r_lrd[63:0]};
                n_mask = r_mask | (r_mask << 1);
                n_r    = p_nr;
                n_c    = p_nc;
                if (p_at) begin
                    n_done  = 1'b0;
                    n_state = ST_NEXT;
                end else begin
                    n_state = ST_RES_RD;
                end
            end
            // drop a scheduled request or step past it
            ST_NEXT: begin
                if (r_done) begin
                    for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
                        if (j >= int'(r_i)) n_q[j] = r_q[j + 1];
                    end
                    n_qcount = r_qcount - QCW'(1);
                end else begin
                    n_i = r_i + QCW'(1);
                end
                n_ex = r_ex + EXW'(1);
                if (r_maxpar != 5'd0 && n_ex >= EXW'(r_maxpar)) n_state = ST_EMIT_RD;
                else n_state = ST_SEL;
            end
            // emit the current slot, last scheduled first
            ST_EMIT_RD: begin
                fre     = 1'b1;
                n_state = ST_EMIT_N;
            end
            ST_EMIT_N: begin
                n_n     = r_frd;
                n_k     = '0;
                n_state = (r_frd == '0) ? ST_EMIT_END : ST_EMIT_WRD;
            end
            ST_EMIT_WRD: begin
                wre     = 1'b1;
                wra     = WAW'(int'(r_base) * SLOT_DEPTH + int'(r_n) - 1 - int'(r_k));
                n_state = ST_EMIT_OUT;
            end
            ST_EMIT_OUT: begin
                if (!r_ov) begin
                    n_ov = 1'b1;
                    n_od = r_wrd;
                    n_ok = RK_ACK;
                    n_ol = (r_k + FW'(1)) == r_n;
                    n_k  = r_k + FW'(1);
                    n_state = n_ol ? ST_EMIT_END : ST_EMIT_WRD;
                end
            end
            ST_EMIT_END: begin
                fwe     = 1'b1;
                n_base  = r_base + 6'd1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_cnt    <= '0;
            r_qcount <= '0;
            r_i      <= '0;
            r_ex     <= '0;
            r_base   <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_qcount <= n_qcount;
            r_i      <= n_i;
            r_ex     <= n_ex;
            r_base   <= n_base;
            r_ov     <= n_ov;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_q    <= n_q;    r_cur  <= n_cur;
        r_sr   <= n_sr;   r_sq   <= n_sq;   r_dm <= n_dm;  r_dq <= n_dq;
        r_pr   <= n_pr;   r_pc   <= n_pc;   r_dr <= n_dr;  r_dc <= n_dc;
        r_r    <= n_r;    r_c    <= n_c;
        r_hop  <= n_hop;  r_acc  <= n_acc;  r_mask <= n_mask;  r_t <= n_t;
        r_slot <= n_slot; r_done <= n_done; r_n <= n_n;  r_k <= n_k;
        r_od   <= n_od;   r_ok   <= n_ok;   r_ol <= n_ol;
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_od;
    assign o_m_tuser  = r_ok;
    assign o_m_tlast  = r_ol;

endmodule

`default_nettype wire

[rtl/core/mpss_checker.sv]
// port checks of the mesh path slot scheduler and their binding
`default_nettype none

module mpss_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_s_tready,
    input wire        o_m_tvalid,
    input wire        i_m_tready,
    input wire [39:0] o_m_tdata
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    // no item taken while a result waits
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !o_m_tvalid)
        else $error("input ready while result pending");

    // reset empties the output and starts the clearing pass
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && !o_s_tready)
        else $error("busy right after reset");

endmodule

bind mesh_path_slot_scheduler mpss_checker u_mpss_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire
